FILE: hw/rtl/bia_pkg.sv
// Package for the bitmap number allocator: shared types, status codes,
// register indexes and field widths. Depends on nothing else.
package bia_pkg;

   localparam int BASE_W   = 16;
   localparam int LENGTH_W = 13;
   localparam int NUMBER_W = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 16;
   localparam int INDEX_W  = 1;
   localparam int BYTE_W   = 8;
   localparam int BIT_W    = 3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [INDEX_W-1:0] CSR_RANGE_BASE   = 1'd0;
   localparam logic [INDEX_W-1:0] CSR_RANGE_LENGTH = 1'd1;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 13'd4096;
   localparam logic [BYTE_W-1:0]   BYTE_FULL    = 8'hFF;

   // Command to the byte unit: set the lowest clear bit, or clear a given bit.
   typedef struct packed {
      logic             clr;
      logic [BIT_W-1:0] bit_sel;
   } byte_cmd_type;

   // Answer of the byte unit.
   typedef struct packed {
      logic              full;
      logic [BIT_W-1:0]  zbit;
      logic [BYTE_W-1:0] wdata;
   } byte_res_type;

endpackage

FILE: hw/rtl/bia_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
module bia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bia_byte_unit.sv
// Shared byte unit: finds the lowest clear bit of a bitmap byte and builds
// the updated byte for a set or a clear. Depends on bia_pkg.
module bia_byte_unit (
   input  logic [bia_pkg::BYTE_W-1:0] data,
   input  bia_pkg::byte_cmd_type      cmd,
   output bia_pkg::byte_res_type      res
);

   logic [bia_pkg::BIT_W-1:0]  zbit;
   logic [bia_pkg::BIT_W-1:0]  sel;
   logic [bia_pkg::BYTE_W-1:0] mask;

   // Scanning downwards leaves the lowest clear bit in zbit.
   always_comb begin
      zbit = '0;
      for (int i = bia_pkg::BYTE_W - 1; i >= 0; i--) begin
         if (!data[i]) begin
            zbit = bia_pkg::BIT_W'(i);
         end
      end
      sel       = cmd.clr ? cmd.bit_sel : zbit;
      mask      = bia_pkg::BYTE_W'(1) << sel;
      res.full  = (data == bia_pkg::BYTE_FULL);
      res.zbit  = zbit;
      res.wdata = cmd.clr ? (data & ~mask) : (data | mask);
   end

endmodule

FILE: hw/rtl/bitmap_id_allocator.sv
// Top level of the bitmap number allocator: register port, sequencer and
// bitmap memory. Depends on bia_pkg, bia_ram and bia_byte_unit.
//
//   Channel   Ports                              Handshake
//   request   req_op, req_number_in              start high while busy low
//   response  rsp_status, rsp_number_out         rsp_valid, one cycle, no stall
//   config    csr_index, csr_wdata               csr_we, taken at once
//
// After reset the block sweeps the bitmap memory, one byte a cycle, to clear
// all MAP_BYTES bytes of it (512 at the default size), and busy stays high
// for the whole sweep. An allocate request streams through the bitmap one
// byte a cycle through the memory's registered read port, until it finds a
// byte with a clear bit or runs past the live length. A release request
// reads the byte, then modifies it and writes it back; a number outside the
// range is answered at once without a memory access. The response appears in
// the first cycle with busy low again and the receiver cannot hold it off; the
// next request may be accepted in that same cycle.
module bitmap_id_allocator #(
   parameter int MAX_NUMBERS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [bia_pkg::NUMBER_W-1:0]   req_number_in,
   // Response channel.
   output logic                           rsp_valid,
   output logic [bia_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bia_pkg::NUMBER_W-1:0]   rsp_number_out,
   // Configuration port.
   input  logic                           csr_we,
   input  logic [bia_pkg::INDEX_W-1:0]    csr_index,
   input  logic [bia_pkg::CSR_W-1:0]      csr_wdata
);

   // Bitmap geometry follows from the number of managed bits.
   localparam int MAP_BYTES = (MAX_NUMBERS + 7) / 8;
   localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CAP_W     = $clog2(MAX_NUMBERS + 1);
   localparam int LW        = (CAP_W > bia_pkg::LENGTH_W) ? CAP_W : bia_pkg::LENGTH_W;
   localparam int NW        = AW + bia_pkg::BIT_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_REL_RD = 3'd3;
   localparam logic [2:0] S_REL_WR = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [AW:0]                      idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    chk_ff, chk_in;
   logic [AW-1:0]                    rel_addr_ff, rel_addr_in;
   logic [bia_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bia_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [bia_pkg::NUMBER_W-1:0]     rsp_number_ff, rsp_number_in;
   logic [bia_pkg::BASE_W-1:0]       base_ff;
   logic [bia_pkg::LENGTH_W-1:0]     length_ff;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic [bia_pkg::BYTE_W-1:0]       ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic [bia_pkg::BYTE_W-1:0]       ram_rdata;

   bia_pkg::byte_cmd_type            unit_cmd;
   bia_pkg::byte_res_type            unit_res;

   logic [LW-1:0]                    len_ext;
   logic [LW-1:0]                    live_len;
   logic [AW:0]                      nbytes;
   logic                             issue;
   logic [NW-1:0]                    found_idx;
   logic [bia_pkg::NUMBER_W-1:0]     rel_num;
   logic                             in_range;

   // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         length_ff <= bia_pkg::LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bia_pkg::CSR_RANGE_BASE:   base_ff   <= csr_wdata[bia_pkg::BASE_W-1:0];
            bia_pkg::CSR_RANGE_LENGTH: length_ff <= csr_wdata[bia_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // The live length is the configured length capped at the bitmap size, and
   // the scan covers every byte that holds at least one bit of it.
   assign len_ext  = LW'(length_ff);
   assign live_len = (len_ext > LW'(MAX_NUMBERS)) ? LW'(MAX_NUMBERS) : len_ext;
   assign nbytes   = (AW + 1)'((LW + 1)'(live_len) + (LW + 1)'(7) >> 3);

   // Release range check: base <= number < base + live length, without wrap.
   assign rel_num  = req_number_in - base_ff;
   assign in_range = (req_number_in >= base_ff) && (32'(rel_num) < 32'(live_len));

   assign issue     = (idx_ff < nbytes);
   assign found_idx = {chk_ff, unit_res.zbit};

   assign unit_cmd.clr     = (state_ff == S_REL_WR);
   assign unit_cmd.bit_sel = bit_ff;

   bia_byte_unit u_byte_unit (
      .data (ram_rdata),
      .cmd  (unit_cmd),
      .res  (unit_res)
   );

   bia_ram #(
      .WIDTH (bia_pkg::BYTE_W),
      .DEPTH (MAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      chk_in        = chk_ff;
      rel_addr_in   = rel_addr_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_number_in = rsp_number_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_ff;
      ram_wdata     = unit_res.wdata;
      ram_raddr     = idx_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zeros through the bitmap after reset.
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = '0;
            if (idx_ff == (AW + 1)'(MAP_BYTES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_op == bia_pkg::OP_ALLOC) begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end else if (in_range) begin
                  rel_addr_in = rel_num[NW-1:bia_pkg::BIT_W];
                  bit_in      = rel_num[bia_pkg::BIT_W-1:0];
                  state_in    = S_REL_RD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bia_pkg::ST_RANGE;
                  rsp_number_in = '0;
               end
            end
         end
         S_SCAN: begin
            // One byte address goes out each cycle while the byte read in
            // the previous cycle is examined.
            pend_in = issue;
            chk_in  = idx_ff[AW-1:0];
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff && !unit_res.full) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (32'(found_idx) >= 32'(live_len)) begin
                  // The lowest clear bit lies past the end of the range.
                  rsp_status_in = bia_pkg::ST_FULL;
                  rsp_number_in = '0;
               end else begin
                  ram_we        = 1'b1;
                  rsp_status_in = bia_pkg::ST_OK;
                  rsp_number_in = base_ff + bia_pkg::NUMBER_W'(found_idx);
               end
            end else if (!issue) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bia_pkg::ST_FULL;
               rsp_number_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_REL_RD: begin
            ram_raddr = rel_addr_ff;
            state_in  = S_REL_WR;
         end
         S_REL_WR: begin
            // Clearing a bit that is already clear is harmless.
            ram_we        = 1'b1;
            ram_waddr     = rel_addr_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = bia_pkg::ST_OK;
            rsp_number_in = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      rel_addr_ff   <= rel_addr_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_number_out = rsp_number_ff;

endmodule

FILE: hw/rtl/bia_checker.sv
// Port-level checker for the bitmap number allocator and its bind statement.
// Depends on bia_pkg and on the ports of bitmap_id_allocator.
module bia_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [bia_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bia_pkg::NUMBER_W-1:0]   rsp_number_out
);

   // Reset starts the clearing sweep, so no request is taken straight after.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // An accepted request either keeps the block busy or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither worked on nor answered");

   // A response only follows work or an accepted request.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response without a request");

   // Failed requests report number zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bia_pkg::ST_OK) |-> (rsp_number_out == '0))
      else $error("failed response carries a number");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_number_out (rsp_number_out)
);
